// File: rtl/assert_macros.svh
// assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

// File: rtl/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] StartWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [63:0] BlockBits = 64'd512;
  localparam logic KindByte = 1'b0;

  // byte source written into the block buffer
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } src_sel_e;

  // controller to datapath
  typedef struct packed {
    logic       buf_we;
    logic [5:0] buf_addr;
    src_sel_e   buf_src;
    logic       len_latch;
    logic       sched_load;
    logic       round_init;
    logic       round_en;
    logic [5:0] round_idx;
    logic       hash_add;
    logic       hash_init;
    logic       bits_add;
    logic       out_load;
    logic [2:0] out_idx;
  } dp_cmd_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned amt);
    ror32 = (v >> amt) | (v << (32 - amt));
  endfunction

endpackage

// File: rtl/sha256_dpath.sv
`timescale 1ns / 1ps
module sha256_dpath import sha256_pkg::*; (
  input  logic        clk_i,
  input  dp_cmd_t     cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  fill_i,
  output logic [31:0] out_word_o
);

  logic [63:0] bits_q, len_q;
  logic [31:0] w_q [16];
  logic [31:0] hw_q [8];
  logic [31:0] r_q [8];
  logic [7:0]  wbyte;
  logic [31:0] s0, s1, w_new, wt, x1, x2, big0, big1, pick, vote;

  always_comb begin
    case (cmd_i.buf_src)
      SRC_DATA: wbyte = data_byte_i;
      SRC_PAD:  wbyte = PadByte;
      SRC_ZERO: wbyte = 8'h00;
      default:  wbyte = len_q[8*(7-cmd_i.buf_addr[2:0]) +: 8];
    endcase
  end

  // bit count, cleared by hash_init
  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_init) bits_q <= '0;
    else if (cmd_i.bits_add) bits_q <= bits_q + BlockBits;
    if (cmd_i.len_latch) len_q <= bits_q + {55'd0, fill_i, 3'd0};
  end

  // rolling 16-word schedule
  assign s0 = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign wt = w_q[0];

  // block bytes land directly in the schedule words, big-endian within a word;
  // every byte is rewritten before the next compression
  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_we) begin
      w_q[cmd_i.buf_addr[5:2]][8*(3-cmd_i.buf_addr[1:0]) +: 8] <= wbyte;
    end else if (cmd_i.round_en) begin
      for (int t = 0; t < 15; t++) w_q[t] <= w_q[t+1];
      w_q[15] <= w_new;
    end
  end

  assign big1 = ror32(r_q[4], 6) ^ ror32(r_q[4], 11) ^ ror32(r_q[4], 25);
  assign pick = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
  assign x1 = r_q[7] + big1 + pick + RoundConst[cmd_i.round_idx] + wt;
  assign big0 = ror32(r_q[0], 2) ^ ror32(r_q[0], 13) ^ ror32(r_q[0], 22);
  assign vote = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
  assign x2 = big0 + vote;

  always_ff @(posedge clk_i) begin
    if (cmd_i.round_init) begin
      r_q <= hw_q;
    end else if (cmd_i.round_en) begin
      r_q[7] <= r_q[6]; r_q[6] <= r_q[5]; r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + x1;
      r_q[3] <= r_q[2]; r_q[2] <= r_q[1]; r_q[1] <= r_q[0];
      r_q[0] <= x1 + x2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_init) hw_q <= StartWords;
    else if (cmd_i.hash_add) begin
      for (int t = 0; t < 8; t++) hw_q[t] <= hw_q[t] + r_q[t];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_word_o <= hw_q[cmd_i.out_idx];
  end

endmodule

// File: rtl/sha256_ctrl.sv
`timescale 1ns / 1ps
module sha256_ctrl import sha256_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       kind_i,
  output logic       in_stall_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [2:0] word_index_o,
  output logic       last_word_o,
  output logic [5:0] fill_o,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_PAD   = 8'b0000_0100,
    ST_LOAD  = 8'b0000_1000,
    ST_ROUND = 8'b0001_0000,
    ST_ADD   = 8'b0010_0000,
    ST_EMIT  = 8'b0100_0000,
    ST_WAIT  = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] fill_q, fill_d, cnt_q, cnt_d;
  logic       fin_q, fin_d, outv_q, outv_d;
  logic [2:0] oidx_q, oidx_d;
  logic       acc;
  logic       pad_done;

  assign in_stall_o = (state_q != ST_IDLE);
  assign acc = in_valid_i && !in_stall_o;
  assign out_valid_o = outv_q;
  assign word_index_o = oidx_q;
  assign last_word_o = (oidx_q == 3'd7);
  assign fill_o = fill_q;
  // pad byte landed in the last slot, nothing left to write in this block
  assign pad_done = (cnt_q == 6'd0) && (fill_q == 6'd63);

  always_comb begin
    state_d = state_q; fill_d = fill_q; cnt_d = cnt_q; fin_d = fin_q;
    outv_d = outv_q; oidx_d = oidx_q;
    cmd_o = '0;
    cmd_o.buf_addr = fill_q;
    cmd_o.buf_src = SRC_DATA;
    cmd_o.round_idx = cnt_q;
    cmd_o.out_idx = oidx_q;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.hash_init = 1'b1;
        fill_d = '0;
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          if (kind_i == KindByte) begin
            cmd_o.buf_we = 1'b1;
            fill_d = fill_q + 6'd1;
            fin_d = 1'b0;
            if (fill_q == 6'd63) state_d = ST_LOAD;
          end else begin
            cmd_o.buf_we = 1'b1;
            cmd_o.buf_src = SRC_PAD;
            cmd_o.len_latch = 1'b1;
            fin_d = 1'b1;
            cnt_d = fill_q + 6'd1;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // zero fill, then length in the last eight bytes if the length fits in this block
        cmd_o.buf_we = 1'b1;
        cmd_o.buf_addr = cnt_q;
        if (cnt_q >= 6'd56 && fill_q < 6'd56) cmd_o.buf_src = SRC_LEN;
        else cmd_o.buf_src = SRC_ZERO;
        if (pad_done) cmd_o.buf_we = 1'b0;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63 || pad_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.sched_load = 1'b1;
        cmd_o.round_init = 1'b1;
        cnt_d = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) state_d = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.hash_add = 1'b1;
        if (!fin_q) begin
          cmd_o.bits_add = 1'b1;
          fill_d = '0;
          state_d = ST_IDLE;
        end else if (fill_q >= 6'd56) begin
          // length did not fit, run one more all-padding block
          fill_d = '0;
          cnt_d = '0;
          state_d = ST_PAD;
        end else begin
          oidx_d = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.out_load = 1'b1;
        outv_d = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (!out_stall_i) begin
          outv_d = 1'b0;
          if (oidx_q == 3'd7) state_d = ST_INIT;
          else begin
            oidx_d = oidx_q + 3'd1;
            state_d = ST_EMIT;
          end
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT; fill_q <= '0; cnt_q <= '0; fin_q <= 1'b0;
      outv_q <= 1'b0; oidx_q <= '0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; cnt_q <= cnt_d; fin_q <= fin_d;
      outv_q <= outv_d; oidx_q <= oidx_d;
    end
  end

endmodule

// File: rtl/sha256_stream_hasher_core.sv
// each byte goes into the block buffer; the 64th byte of a block starts a compression
// (one round per cycle through the shared round unit), a finish item takes padding plus one
// or two compressions, then eight digest items, each held until the receiver takes it
// throughput: one byte per cycle inside a block; no byte is taken while a block is compressed
// reset: asynchronous active low; the init state after release loads the initial hash words
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_stream_hasher_core import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  dp_cmd_t    cmd;
  logic [5:0] fill;

  // sequencer: buffering, padding, rounds and digest readout
  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .kind_i, .in_stall_o, .out_stall_i,
    .out_valid_o, .word_index_o, .last_word_o, .fill_o(fill), .cmd_o(cmd)
  );

  // schedule words double as the block buffer, round unit, hash words
  sha256_dpath u_dpath (
    .clk_i, .cmd_i(cmd), .data_byte_i, .fill_i(fill), .out_word_o(digest_word_o)
  );

  // an item is never taken while a digest word is pending
  `ASSERT_NEVER(a_no_in_during_out, clk_i, rst_ni, out_valid_o && !in_stall_o)
  // a stalled digest word holds
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(digest_word_o)))
  // rounds and buffer loads do not overlap
  `ASSERT_NEVER(a_cmd_excl, clk_i, rst_ni, cmd.round_en && cmd.sched_load)

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import sha256_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        kind_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_stream_hasher_core dut (.*);

  // one item offered to the hasher
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } msg_item_t;

  // one digest word as it should leave the block
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  localparam logic KindFinish = 1'b1;
  localparam int unsigned CycleLimit = 400000;

  msg_item_t   pending_items[$];
  digest_exp_t digest_queue[$];

  // predictor state
  logic [31:0] chain_words [8];
  logic [7:0]  blk_buf [64];
  int unsigned blk_fill;
  logic [63:0] bits_done;

  int unsigned errors;
  int unsigned cycle_count;
  bit          sender_idle_ok;
  bit          recv_idle_ok;
  bit          hold_recv;
  int unsigned hold_cycles;
  bit          stim_done;
  // stall as seen at the last rising edge decides acceptance
  logic        in_stall_o_q;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] s0, s1, t1, t2, ch, maj;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) r[i] = chain_words[i];
    for (int t = 0; t < 64; t++) begin
      s1 = rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25);
      ch = (r[4] & r[5]) ^ (~r[4] & r[6]);
      t1 = r[7] + s1 + ch + RoundConst[t] + w[t];
      s0 = rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22);
      maj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
      t2 = s0 + maj;
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_words[i] += r[i];
  endtask

  task automatic hasher_restart();
    for (int i = 0; i < 8; i++) chain_words[i] = StartWords[i];
    for (int i = 0; i < 64; i++) blk_buf[i] = '0;
    blk_fill = 0;
    bits_done = '0;
  endtask

  // advance the predictor by one accepted item
  task automatic predict_digest(input msg_item_t it);
    int unsigned pos;
    logic [63:0] total;
    if (it.kind == KindByte) begin
      blk_buf[blk_fill] = it.data;
      blk_fill++;
      if (blk_fill == 64) begin
        compress_block();
        bits_done += BlockBits;
        blk_fill = 0;
      end
    end else begin
      pos = blk_fill;
      total = bits_done + 64'(pos * 8);
      blk_buf[pos] = PadByte;
      pos++;
      // more than 55 bytes buffered: length spills into an extra block
      if (pos > 56) begin
        while (pos < 64) begin blk_buf[pos] = '0; pos++; end
        compress_block();
        pos = 0;
      end
      while (pos < 56) begin blk_buf[pos] = '0; pos++; end
      for (int i = 0; i < 8; i++) blk_buf[56+i] = total[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++)
        digest_queue.push_back('{word: chain_words[i], idx: 3'(i), last: (i == 7)});
      hasher_restart();
    end
  endtask

  task automatic add_message(input int unsigned len);
    msg_item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      it.kind = KindByte;
      it.data = 8'($urandom_range(0, 255));
      pending_items.push_back(it);
    end
    // finish carries a random, ignored data byte
    it.kind = KindFinish;
    it.data = 8'($urandom_range(0, 255));
    pending_items.push_back(it);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: inputs change on the falling edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      kind_i      <= 1'b0;
      data_byte_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o_q) begin
        predict_digest('{kind: kind_i, data: data_byte_i});
        void'(pending_items.pop_front());
      end
      if ((!in_valid_i || !in_stall_o_q) && pending_items.size() > 0 &&
          (!sender_idle_ok || $urandom_range(0, 99) >= 16) &&
          !(pending_items[0].kind === 1'bx)) begin
        in_valid_i  <= 1'b1;
        kind_i      <= pending_items[0].kind;
        data_byte_i <= pending_items[0].data;
      end else if (!in_valid_i || !in_stall_o_q) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_stall_o_q <= 1'b1;
    else in_stall_o_q <= in_stall_o;
  end

  // receiver stall, also on the falling edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_recv) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall_i <= recv_idle_ok && ($urandom_range(0, 99) < 16);
    end
  end

  // monitor: sample outputs at the rising edge
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest word actual=%h idx=%0d last=%b", $time,
                 digest_word_o, word_index_o, last_word_o);
        errors++;
      end else begin
        if (digest_word_o !== digest_queue[0].word) begin
          $display("%0t: digest_word expected=%h actual=%h", $time,
                   digest_queue[0].word, digest_word_o);
          errors++;
        end
        if (word_index_o !== digest_queue[0].idx) begin
          $display("%0t: word_index expected=%0d actual=%0d", $time,
                   digest_queue[0].idx, word_index_o);
          errors++;
        end
        if (last_word_o !== digest_queue[0].last) begin
          $display("%0t: last_word expected=%b actual=%b", $time,
                   digest_queue[0].last, last_word_o);
          errors++;
        end
        void'(digest_queue.pop_front());
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("sha256_stream_hasher_core verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || digest_queue.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    msg_item_t it;
    errors = 0;
    cycle_count = 0;
    hold_recv = 1'b0;
    hold_cycles = 0;
    stim_done = 1'b0;
    sender_idle_ok = 1'b0;
    recv_idle_ok = 1'b0;
    in_valid_i = 1'b0;
    kind_i = 1'b0;
    data_byte_i = '0;
    out_stall_i = 1'b0;
    hasher_restart();
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: empty message, single 0x00 and 0xff bytes, boundary lengths
    add_message(0);
    it = '{kind: KindByte, data: 8'h00}; pending_items.push_back(it);
    it = '{kind: KindFinish, data: 8'hff}; pending_items.push_back(it);
    it = '{kind: KindByte, data: 8'hff}; pending_items.push_back(it);
    it = '{kind: KindFinish, data: 8'h00}; pending_items.push_back(it);
    wait_drained();
    // no idling stretch: 55 and 56 bytes straddle the extra pad block
    add_message(55);
    add_message(56);
    wait_drained();

    sender_idle_ok = 1'b1;
    recv_idle_ok = 1'b1;
    add_message(64);
    add_message(63);
    wait_drained();

    // receiver holds off long while the sender keeps offering
    add_message(3);
    add_message(5);
    add_message(2);
    hold_recv = 1'b1;
    while (hold_cycles < 600) @(posedge clk_i);
    hold_recv = 1'b0;
    wait_drained();

    // random messages, mostly short (up to 20 bytes), a few of 57 to 140 bytes
    while (pending_items.size() == 0 && cycle_count < CycleLimit) begin
      for (int m = 0; m < 7; m++)
        add_message($urandom_range(0, 99) < 15 ? $urandom_range(57, 140)
                                               : $urandom_range(0, 20));
      wait_drained();
      break;
    end
    stim_done = 1'b1;
    repeat (200) @(posedge clk_i);
    if (errors == 0 && digest_queue.size() == 0) begin
      $display("sha256_stream_hasher_core verification clean");
    end else begin
      $display("sha256_stream_hasher_core verification failed");
    end
    $finish;
  end
endmodule
